>>> rtl/asq_pkg.sv
package asq_pkg;

  localparam int unsigned NUM_W    = 32;
  localparam int unsigned ROOT_W   = 17;
  localparam int unsigned GUESS_W  = 17;
  localparam int unsigned FRAC_W   = 23;
  localparam int unsigned EXP_W    = 8;
  localparam int unsigned EXP_BIAS = 127;
  localparam int unsigned POS_W    = 5;

  // Added to the single-precision pattern before the halving shift.
  localparam logic [NUM_W-1:0] SQRT_MAGIC = 32'h3f7a63d7;

  // Largest biased exponent whose truncated value still fits in GUESS_W bits.
  localparam logic [EXP_W-1:0] EXP_GUESS_MAX = EXP_W'(EXP_BIAS + GUESS_W - 1);
  // Biased exponent at which the 24-bit significand is an integer.
  localparam logic [EXP_W-1:0] EXP_INT = EXP_W'(EXP_BIAS + FRAC_W);

  // One restoring-division step per quotient bit.
  localparam int unsigned DIV_STEPS = NUM_W;

  // Number and its single-precision bit pattern.
  typedef struct packed {
    logic [NUM_W-1:0] number;
    logic [NUM_W-1:0] bits;
  } fcv_t;

  // Number and its integer first guess.
  typedef struct packed {
    logic [NUM_W-1:0]   number;
    logic [GUESS_W-1:0] guess;
  } gss_t;

endpackage

>>> rtl/asq_fcvt.sv
module asq_fcvt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [asq_pkg::NUM_W-1:0]    in_number,
  output logic                         out_valid,
  input  logic                         out_ready,
  output asq_pkg::fcv_t                out_data
);

  // Stage 1 finds the leading one, stage 2 normalizes and rounds.
  logic                         s1_valid_r;
  logic [asq_pkg::NUM_W-1:0]    s1_number_r;
  logic [asq_pkg::POS_W-1:0]    s1_pos_r;
  logic                         s1_zero_r;
  logic                         s2_valid_r;
  asq_pkg::fcv_t                s2_data_r;

  logic                         s1_ready;
  logic                         s2_ready;
  logic [asq_pkg::POS_W-1:0]    pos_nxt;
  logic [asq_pkg::NUM_W-1:0]    norm;
  logic                         round_up;
  logic [asq_pkg::NUM_W-1:0]    bits_nxt;

  assign s2_ready = !s2_valid_r || out_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  always_comb begin
    pos_nxt = '0;
    for (int i = 0; i < asq_pkg::NUM_W; i++) begin
      if (in_number[i]) begin
        pos_nxt = asq_pkg::POS_W'(i);
      end
    end
  end

  // Round to nearest even; a carry out of the fraction bumps the exponent.
  always_comb begin
    norm     = s1_number_r << (asq_pkg::POS_W'(asq_pkg::NUM_W - 1) - s1_pos_r);
    round_up = norm[7] && ((|norm[6:0]) || norm[8]);
    bits_nxt = {1'b0, asq_pkg::EXP_W'(asq_pkg::EXP_BIAS) + asq_pkg::EXP_W'(s1_pos_r),
                {asq_pkg::FRAC_W{1'b0}}}
             + {{(asq_pkg::NUM_W - asq_pkg::FRAC_W){1'b0}}, norm[30:8]}
             + {{(asq_pkg::NUM_W - 1){1'b0}}, round_up};
    if (s1_zero_r) begin
      bits_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_number_r <= in_number;
      s1_pos_r    <= pos_nxt;
      s1_zero_r   <= (in_number == '0);
    end
    if (s2_ready && s1_valid_r) begin
      s2_data_r.number <= s1_number_r;
      s2_data_r.bits   <= bits_nxt;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_data  = s2_data_r;

endmodule

>>> rtl/asq_guess.sv
module asq_guess (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  asq_pkg::fcv_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output asq_pkg::gss_t out_data
);

  // Stage 3 adds the magic constant and halves, stage 4 truncates to an integer.
  logic                         s3_valid_r;
  logic [asq_pkg::NUM_W-1:0]    s3_number_r;
  logic [asq_pkg::NUM_W-2:0]    s3_half_r;
  logic                         s4_valid_r;
  asq_pkg::gss_t                s4_data_r;

  logic                         s3_ready;
  logic                         s4_ready;
  logic [asq_pkg::NUM_W-1:0]    sum;
  logic [asq_pkg::EXP_W-1:0]    expo;
  logic [asq_pkg::FRAC_W:0]     sig;
  logic [asq_pkg::EXP_W-1:0]    shamt;
  logic [asq_pkg::FRAC_W:0]     shifted;
  logic [asq_pkg::GUESS_W-1:0]  guess_nxt;

  assign s4_ready = !s4_valid_r || out_ready;
  assign s3_ready = !s3_valid_r || s4_ready;
  assign in_ready = s3_ready;

  assign sum = in_data.bits + asq_pkg::SQRT_MAGIC;

  // The halved pattern has a clear sign bit, so only the exponent matters.
  always_comb begin
    expo    = s3_half_r[asq_pkg::NUM_W-2:asq_pkg::FRAC_W];
    sig     = {1'b1, s3_half_r[asq_pkg::FRAC_W-1:0]};
    shamt   = asq_pkg::EXP_INT - expo;
    shifted = sig >> shamt[4:0];
    if (expo < asq_pkg::EXP_W'(asq_pkg::EXP_BIAS)) begin
      guess_nxt = '0;
    end else if (expo > asq_pkg::EXP_GUESS_MAX) begin
      // Cannot happen for a 32-bit number; the guess stays below 2^16.
      guess_nxt = '1;
    end else begin
      guess_nxt = shifted[asq_pkg::GUESS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (s3_ready) begin
        s3_valid_r <= in_valid;
      end
      if (s4_ready) begin
        s4_valid_r <= s3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && in_valid) begin
      s3_number_r <= in_data.number;
      s3_half_r   <= sum[asq_pkg::NUM_W-1:1];
    end
    if (s4_ready && s3_valid_r) begin
      s4_data_r.number <= s3_number_r;
      s4_data_r.guess  <= guess_nxt;
    end
  end

  assign out_valid = s4_valid_r;
  assign out_data  = s4_data_r;

endmodule

>>> rtl/asq_div.sv
module asq_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  asq_pkg::gss_t               in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [asq_pkg::ROOT_W-1:0]  out_root
);

  localparam int unsigned STEPS = asq_pkg::DIV_STEPS;
  localparam int unsigned DW    = asq_pkg::NUM_W;
  localparam int unsigned GW    = asq_pkg::GUESS_W;

  // Each step holds a word that starts as the dividend; its top bit moves into
  // the partial remainder and the new quotient bit enters at the bottom, so
  // after the last step the word is the quotient.
  logic [STEPS-1:0]   v_r;
  logic [STEPS-1:0]   rdy;
  logic [DW-1:0]      wrd_r  [STEPS];
  logic [GW-1:0]      rem_r  [STEPS];
  logic [GW-1:0]      gs_r   [STEPS];
  logic [STEPS-1:0]   zero_r;
  logic [STEPS-1:0]   n0_r;

  logic                 fin_valid_r;
  logic [asq_pkg::ROOT_W-1:0] fin_root_r;
  logic                 fin_ready;
  logic [DW:0]          fin_sum;

  assign fin_ready = !fin_valid_r || out_ready;
  assign in_ready  = rdy[0];

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    logic            src_v;
    logic [DW-1:0]   src_wrd;
    logic [GW-1:0]   src_rem;
    logic [GW-1:0]   src_gs;
    logic            src_zero;
    logic            src_n0;
    logic            nxt_rdy;
    logic [GW:0]     rem_sh;
    logic [GW:0]     diff;
    logic            qbit;

    if (g == 0) begin : g_head
      assign src_v    = in_valid;
      assign src_wrd  = in_data.number;
      assign src_rem  = '0;
      assign src_gs   = in_data.guess;
      assign src_zero = (in_data.guess == '0);
      assign src_n0   = in_data.number[0];
    end else begin : g_body
      assign src_v    = v_r[g-1];
      assign src_wrd  = wrd_r[g-1];
      assign src_rem  = rem_r[g-1];
      assign src_gs   = gs_r[g-1];
      assign src_zero = zero_r[g-1];
      assign src_n0   = n0_r[g-1];
    end

    if (g == STEPS - 1) begin : g_last
      assign nxt_rdy = fin_ready;
    end else begin : g_mid
      assign nxt_rdy = rdy[g+1];
    end

    assign rdy[g]  = !v_r[g] || nxt_rdy;
    assign rem_sh  = {src_rem, src_wrd[DW-1]};
    assign diff    = rem_sh - {1'b0, src_gs};
    assign qbit    = !diff[GW];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (rdy[g]) begin
        v_r[g] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[g] && src_v) begin
        wrd_r[g]  <= {src_wrd[DW-2:0], qbit};
        rem_r[g]  <= qbit ? diff[GW-1:0] : rem_sh[GW-1:0];
        gs_r[g]   <= src_gs;
        zero_r[g] <= src_zero;
        n0_r[g]   <= src_n0;
      end
    end
  end

  assign fin_sum = {{(DW + 1 - GW){1'b0}}, gs_r[STEPS-1]} + {1'b0, wrd_r[STEPS-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (fin_ready) begin
      fin_valid_r <= v_r[STEPS-1];
    end
  end

  // A zero guess only comes from the numbers 0 and 1, which are their own root.
  always_ff @(posedge clk) begin
    if (fin_ready && v_r[STEPS-1]) begin
      if (zero_r[STEPS-1]) begin
        fin_root_r <= {{(asq_pkg::ROOT_W - 1){1'b0}}, n0_r[STEPS-1]};
      end else begin
        fin_root_r <= fin_sum[asq_pkg::ROOT_W:1];
      end
    end
  end

  assign out_valid = fin_valid_r;
  assign out_root  = fin_root_r;

endmodule

>>> rtl/approx_integer_sqrt.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    in_number  [31:0] unsigned
// out_      output     out_valid/out_ready  out_root   [16:0] unsigned
//
// Every beat passes 37 register stages: two stages of float conversion, two
// stages for the magic add and truncation, 32 stages of restoring division (one
// quotient bit per stage) and one output register. The first stage loads at the
// accepting edge; out_root is driven from the output register.
// A new beat is accepted every cycle while the output side keeps taking.
// rst_n is synchronous and clears only the valid bits; payload is not reset.
// Each stage moves when it is empty or the stage after it moves, so a stalled
// output holds its beat while earlier empty stages still fill up.
module approx_integer_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [asq_pkg::NUM_W-1:0]   in_number,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [asq_pkg::ROOT_W-1:0]  out_root
);

  // Conversion of the number to its single-precision bit pattern.
  logic          fcv_valid;
  logic          fcv_ready;
  asq_pkg::fcv_t fcv_data;

  // Integer first guess from the bit hack.
  logic          gss_valid;
  logic          gss_ready;
  asq_pkg::gss_t gss_data;

  asq_fcvt u_fcvt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_number (in_number),
    .out_valid (fcv_valid),
    .out_ready (fcv_ready),
    .out_data  (fcv_data)
  );

  asq_guess u_guess (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fcv_valid),
    .in_ready  (fcv_ready),
    .in_data   (fcv_data),
    .out_valid (gss_valid),
    .out_ready (gss_ready),
    .out_data  (gss_data)
  );

  // The Newton step: number / guess through the division pipeline, then the
  // average of guess and quotient in the output register.
  asq_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (gss_valid),
    .in_ready  (gss_ready),
    .in_data   (gss_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_root  (out_root)
  );

endmodule

>>> rtl/asq_checker.sv
module asq_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [asq_pkg::NUM_W-1:0]   in_number,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [asq_pkg::ROOT_W-1:0]  out_root
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // A taking output side lets every stage move, so the input is ready.
  a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

  // An empty output register must never block the input.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output");

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_root))
    else $error("result beat changed while stalled");

  // A stalled input beat stays offered with the same number.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_number))
    else $error("input beat changed while stalled");

endmodule

bind approx_integer_sqrt asq_checker u_asq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_number (in_number),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_root  (out_root)
);

>>> dv/tb_approx_integer_sqrt.sv
module tb_approx_integer_sqrt;
  timeunit 1ns;
  timeprecision 1ps;

  // Number of random beats that follow the directed ones.
  localparam int unsigned RANDOM_BEATS = 850;
  // A little more than the latency of the block.
  localparam int unsigned DRAIN_CYCLES = 48;
  // Beats accepted before the receiver starts its long hold-off, and its length.
  localparam int unsigned HOLD_AFTER  = 400;
  localparam int unsigned HOLD_CYCLES = 150;
  // Window (in beats) during which a side never idles.
  localparam int unsigned CALM_FROM = 200;
  localparam int unsigned CALM_TO   = 350;
  localparam int unsigned IDLE_PCT  = 24;

  // One expected beat on the result channel, kept with the number it came from
  // so that a mismatch report says which input went wrong.
  typedef struct {
    logic [asq_pkg::NUM_W-1:0]  number;
    logic [asq_pkg::ROOT_W-1:0] root;
  } root_check_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [asq_pkg::NUM_W-1:0]  in_number = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [asq_pkg::ROOT_W-1:0] out_root;

  logic [asq_pkg::NUM_W-1:0] numbers_to_send[$];
  root_check_t               expected_roots[$];

  int unsigned numbers_planned = 0;
  int unsigned numbers_taken = 0;
  int unsigned roots_seen = 0;
  int unsigned fail_count = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic        in_fire = 1'b0;

  approx_integer_sqrt i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_number (in_number),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_root  (out_root)
  );

  always #1 clk = ~clk;

  // Reset is held low from the start and released on a falling edge, so the
  // block sees it drop cleanly between two sampling points.
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Expected root for one number. The number is first turned into the bit
  // pattern of an IEEE single with round-to-nearest-even, the magic constant
  // is added modulo 2^32 and the sum halved, the new pattern is truncated to an
  // integer guess, and one integer Newton step refines that guess. A guess of
  // zero happens only for 0 and 1, and then the number itself is the root.
  function automatic logic [asq_pkg::ROOT_W-1:0] approx_root(
    input logic [asq_pkg::NUM_W-1:0] number
  );
    logic [63:0]               mant;
    logic [63:0]               rem;
    logic [63:0]               half;
    logic [asq_pkg::NUM_W-1:0] pattern;
    logic [asq_pkg::NUM_W-1:0] biased;
    logic [asq_pkg::NUM_W-1:0] guess;
    int unsigned               msb;
    int unsigned               shift;
    int unsigned               expo;
    pattern = '0;
    if (number != '0) begin
      msb = asq_pkg::NUM_W - 1;
      while (number[msb] == 1'b0) msb--;
      if (msb <= asq_pkg::FRAC_W) begin
        mant = 64'(number) << (asq_pkg::FRAC_W - msb);
      end else begin
        // Bits below the 24-bit significand decide the rounding; a carry out
        // of the significand bumps the exponent.
        shift = msb - asq_pkg::FRAC_W;
        rem   = 64'(number) & ((64'd1 << shift) - 64'd1);
        half  = 64'd1 << (shift - 1);
        mant  = 64'(number) >> shift;
        if (rem > half || (rem == half && mant[0])) mant++;
        if (mant == (64'd1 << (asq_pkg::FRAC_W + 1))) begin
          mant = mant >> 1;
          msb++;
        end
      end
      pattern = {1'b0, asq_pkg::EXP_W'(msb + asq_pkg::EXP_BIAS),
                 mant[asq_pkg::FRAC_W-1:0]};
    end

    biased  = pattern + asq_pkg::SQRT_MAGIC;
    pattern = biased >> 1;

    expo = 32'(pattern[asq_pkg::NUM_W-2:asq_pkg::FRAC_W]);
    if (pattern[asq_pkg::NUM_W-1] || expo < asq_pkg::EXP_BIAS) begin
      guess = '0;
    end else if (expo - asq_pkg::EXP_BIAS >= asq_pkg::NUM_W) begin
      guess = '1;
    end else begin
      mant = 64'(pattern[asq_pkg::FRAC_W-1:0]) | (64'd1 << asq_pkg::FRAC_W);
      if (expo >= asq_pkg::EXP_BIAS + asq_pkg::FRAC_W)
        mant = mant << (expo - asq_pkg::EXP_BIAS - asq_pkg::FRAC_W);
      else
        mant = mant >> (asq_pkg::EXP_BIAS + asq_pkg::FRAC_W - expo);
      guess = (mant > 64'hFFFF_FFFF) ? '1 : mant[asq_pkg::NUM_W-1:0];
    end

    if (guess == '0) return number[asq_pkg::ROOT_W-1:0];
    return asq_pkg::ROOT_W'((64'(guess) + 64'(number / guess)) >> 1);
  endfunction

  // Sender. It only picks a new beat when the current one was taken at the
  // last rising edge (or nothing was offered), so valid and the payload stay
  // put until the handshake completes.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (numbers_to_send.size() != 0 &&
          ((numbers_taken >= CALM_FROM && numbers_taken < CALM_TO) ||
           $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid  <= 1'b1;
        in_number <= numbers_to_send.pop_front();
      end else begin
        in_valid  <= 1'b0;
        in_number <= $urandom;
      end
    end
  end

  // Long hold-off on the result side. It is counted here in cycles while the
  // sender keeps offering beats, which fills the pipeline and must push back
  // through in_ready.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && numbers_taken >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Receiver. Ready is random outside the calm window and the hold-off.
  always @(negedge clk) begin
    if (!rst_n || hold_left != 0) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (roots_seen >= CALM_FROM && roots_seen < CALM_TO) ||
                   $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  // Monitor. Both channels are sampled at the rising edge. An accepted input
  // beat pushes its predicted root; an accepted result beat is checked against
  // the oldest prediction.
  always @(posedge clk) begin
    root_check_t want;
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      roots_seen <= roots_seen + 1;
      if (expected_roots.size() == 0) begin
        fail_count <= fail_count + 1;
        if (fail_count < 10)
          $display("[%0t] result beat with no input pending: root=%0d", $realtime, out_root);
      end else begin
        want = expected_roots.pop_front();
        if (out_root !== want.root) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("[%0t] root mismatch for number 0x%08h: expected %0d, got %0d",
                     $realtime, want.number, want.root, out_root);
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      numbers_taken <= numbers_taken + 1;
      expected_roots.push_back('{number: in_number, root: approx_root(in_number)});
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [asq_pkg::NUM_W-1:0] value;
    logic [asq_pkg::NUM_W-1:0] k;
    logic [asq_pkg::NUM_W-1:0] low_mask;
    logic [asq_pkg::NUM_W-1:0] half_bit;
    int unsigned               msb;
    int unsigned               shift;
    int unsigned               pick;

    // Directed part: the zero-guess inputs, the smallest nontrivial values,
    // exact squares at both ends, the full range, and the rounding corners of
    // the float conversion (exact, tie to even, tie to odd, carry out of the
    // significand into the exponent).
    numbers_to_send.push_back(32'h0000_0000);
    numbers_to_send.push_back(32'h0000_0001);
    numbers_to_send.push_back(32'h0000_0002);
    numbers_to_send.push_back(32'h0000_0003);
    numbers_to_send.push_back(32'h0000_0004);
    numbers_to_send.push_back(32'h0000_0010);
    numbers_to_send.push_back(32'h0001_0000);
    numbers_to_send.push_back(32'h00FF_FFFF);
    numbers_to_send.push_back(32'h0100_0000);
    numbers_to_send.push_back(32'h0100_0001);
    numbers_to_send.push_back(32'h0100_0003);
    numbers_to_send.push_back(32'h01FF_FFFF);
    numbers_to_send.push_back(32'h0200_0002);
    numbers_to_send.push_back(32'h0200_0006);
    numbers_to_send.push_back(32'h5555_5555);
    numbers_to_send.push_back(32'hAAAA_AAAA);
    numbers_to_send.push_back(32'h7FFF_FFFF);
    numbers_to_send.push_back(32'h8000_0000);
    numbers_to_send.push_back(32'hFFFE_0001);
    numbers_to_send.push_back(32'hFFFE_0000);
    numbers_to_send.push_back(32'hFFFF_FF7F);
    numbers_to_send.push_back(32'hFFFF_FF80);
    numbers_to_send.push_back(32'hFFFF_FFFF);

    // Random part, mixed so that every magnitude is reached, not only the
    // large numbers that plain 32-bit draws give.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        value = $urandom;
      end else if (pick < 7) begin
        value = $urandom >> $urandom_range(0, asq_pkg::NUM_W - 1);
      end else if (pick < 9) begin
        // Around an exact square, where the Newton step is most sensitive.
        k     = $urandom_range(1, 65535);
        value = k * k + 32'($urandom_range(0, 2)) - 32'd1;
      end else begin
        // On a rounding boundary of the float conversion.
        msb      = $urandom_range(asq_pkg::FRAC_W + 1, asq_pkg::NUM_W - 1);
        shift    = msb - asq_pkg::FRAC_W;
        value    = $urandom >> (asq_pkg::NUM_W - 1 - msb);
        value[msb] = 1'b1;
        low_mask = (32'd1 << shift) - 32'd1;
        half_bit = 32'd1 << (shift - 1);
        case ($urandom_range(0, 3))
          0: value = (value & ~low_mask) | ((half_bit - 32'd1) & low_mask);
          1: value = (value & ~low_mask) | half_bit;
          2: value = (value & ~low_mask) | ((half_bit + 32'd1) & low_mask);
          default: value = value | ((32'd1 << msb) - 32'd1);
        endcase
      end
      numbers_to_send.push_back(value);
    end
    numbers_planned = numbers_to_send.size();

    while (numbers_taken != numbers_planned) @(posedge clk);
    while (expected_roots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && expected_roots.size() == 0) begin
      $display("tb_approx_integer_sqrt OK");
    end else begin
      $display("tb_approx_integer_sqrt NOT OK");
    end
    $finish;
  end

  // Watchdog. It ends a run that hangs and reports it as NOT OK.
  initial begin
    #200us;
    $display("tb_approx_integer_sqrt NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
rtl/asq_pkg.sv
rtl/asq_fcvt.sv
rtl/asq_guess.sv
rtl/asq_div.sv
rtl/approx_integer_sqrt.sv
rtl/asq_checker.sv
dv/tb_approx_integer_sqrt.sv
